>>> rtl/core/first_fit_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// first_fit_block_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FFBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define FFBA_ASSERT(lbl, prop)
`define FFBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned ADDR_W           = 24;
  localparam int unsigned COUNT_OUT_W      = 7;
  localparam logic [ADDR_W-1:0] RESET_ARENA = 24'd65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SEARCH,
    OP_MARK_BLOCK,
    OP_MARK_HOLE,
    OP_SPLIT
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_APPLY
  } fsm_e;

  typedef struct packed {
    cell_op_e          op;
    logic              req_free;
    logic [ADDR_W:0]   need;
    logic [ADDR_W-1:0] where;
    logic [ADDR_W-1:0] arena;
  } cell_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic              blk;
    logic              live;
    logic              sel;
    logic              past;
    logic              hit;
  } cell_link_t;

endpackage

`default_nettype wire

>>> rtl/core/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One table slot: holds a segment, matches it, and shifts from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_cell #(
  parameter bit HEAD = 1'b0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ffba_pkg::cell_cmd_t          cmd_i,
  input  ffba_pkg::cell_link_t         prev_i,
  output ffba_pkg::cell_link_t         link_o,
  output logic [ffba_pkg::ADDR_W-1:0]  sel_start_o,
  output logic                         sel_exact_o
);

  logic [ffba_pkg::ADDR_W-1:0] start_q, start_d;
  logic [ffba_pkg::ADDR_W-1:0] len_q, len_d;
  logic                        blk_q, blk_d;
  logic                        live_q, live_d;
  logic                        sel_q, sel_d;
  logic                        flag;

  always_comb begin
    if (cmd_i.req_free) begin
      flag = live_q && (start_q == cmd_i.where);
    end else begin
      flag = live_q && !blk_q && ({1'b0, len_q} >= cmd_i.need);
    end
  end

  assign link_o.start = start_q;
  assign link_o.len   = len_q;
  assign link_o.blk   = blk_q;
  assign link_o.live  = live_q;
  assign link_o.sel   = sel_q;
  assign link_o.past  = prev_i.past | sel_q;
  assign link_o.hit   = prev_i.hit | flag;

  assign sel_start_o = sel_q ? start_q : '0;
  assign sel_exact_o = sel_q && ({1'b0, len_q} == cmd_i.need);

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    blk_d   = blk_q;
    live_d  = live_q;
    sel_d   = sel_q;
    case (cmd_i.op)
      ffba_pkg::OP_CLEAR: begin
        start_d = '0;
        len_d   = HEAD ? {cmd_i.arena[ffba_pkg::ADDR_W-1:2], 2'b00} : '0;
        blk_d   = 1'b0;
        live_d  = HEAD;
        sel_d   = 1'b0;
      end
      ffba_pkg::OP_SEARCH: begin
        sel_d = flag && !prev_i.hit;
      end
      ffba_pkg::OP_MARK_BLOCK: begin
        if (sel_q) begin
          blk_d = 1'b1;
        end
      end
      ffba_pkg::OP_MARK_HOLE: begin
        if (sel_q) begin
          blk_d = 1'b0;
        end
      end
      ffba_pkg::OP_SPLIT: begin
        if (sel_q) begin
          len_d = cmd_i.need[ffba_pkg::ADDR_W-1:0];
          blk_d = 1'b1;
        end else if (prev_i.sel) begin
          start_d = prev_i.start + cmd_i.need[ffba_pkg::ADDR_W-1:0];
          len_d   = prev_i.len - cmd_i.need[ffba_pkg::ADDR_W-1:0];
          blk_d   = 1'b0;
          live_d  = 1'b1;
        end else if (prev_i.past) begin
          start_d = prev_i.start;
          len_d   = prev_i.len;
          blk_d   = prev_i.blk;
          live_d  = prev_i.live;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      len_q   <= HEAD ? ffba_pkg::RESET_ARENA : '0;
      blk_q   <= 1'b0;
      live_q  <= HEAD;
      sel_q   <= 1'b0;
    end else begin
      start_q <= start_d;
      len_q   <= len_d;
      blk_q   <= blk_d;
      live_q  <= live_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: search, decide, command the cells, register the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_block_allocator_assert.svh"

module ffba_ctrl #(
  parameter int unsigned MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [ffba_pkg::ADDR_W-1:0]       cfg_wdata_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               in_free_i,
  input  wire  [ffba_pkg::ADDR_W-1:0]       in_bytes_i,
  input  wire  [ffba_pkg::ADDR_W-1:0]       in_where_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [1:0]                        out_status_o,
  output logic [ffba_pkg::ADDR_W-1:0]       out_offset_o,
  output logic [ffba_pkg::COUNT_OUT_W-1:0]  out_count_o,
  input  wire                               found_i,
  input  wire                               sel_exact_i,
  input  wire  [ffba_pkg::ADDR_W-1:0]       sel_start_i,
  output ffba_pkg::cell_cmd_t               cmd_o
);

  ffba_pkg::fsm_e              state_q, state_d;
  logic                        free_q;
  logic [ffba_pkg::ADDR_W:0]   need_q;
  logic [ffba_pkg::ADDR_W-1:0] where_q;
  logic                        found_q;
  logic [CNT_W-1:0]            count_q, count_d;

  logic                        out_valid_q;
  ffba_pkg::status_e           status_q, status_d;
  logic [ffba_pkg::ADDR_W-1:0] offset_q, offset_d;
  logic [CNT_W-1:0]            out_count_q;

  ffba_pkg::cell_op_e          apply_op;
  logic                        in_fire;
  logic                        apply_go;
  logic [ffba_pkg::ADDR_W:0]   need_in;

  assign in_fire  = in_valid_i && in_ready_o;
  assign apply_go = (state_q == ffba_pkg::FSM_APPLY) && (!out_valid_q || out_ready_i);
  assign need_in  = ({1'b0, in_bytes_i} + (ffba_pkg::ADDR_W+1)'(3))
                    & ~(ffba_pkg::ADDR_W+1)'(3);

  // decision for the applied request
  always_comb begin
    apply_op = ffba_pkg::OP_NONE;
    status_d = ffba_pkg::ST_OK;
    offset_d = '0;
    count_d  = count_q;
    if (free_q) begin
      if (found_q) begin
        apply_op = ffba_pkg::OP_MARK_HOLE;
        offset_d = where_q;
      end else begin
        status_d = ffba_pkg::ST_NOTFOUND;
      end
    end else if ((need_q == '0) || !found_q) begin
      status_d = ffba_pkg::ST_NOFIT;
    end else if (sel_exact_i) begin
      apply_op = ffba_pkg::OP_MARK_BLOCK;
      offset_d = sel_start_i;
    end else if (count_q >= CNT_W'(MAX_SEGMENTS)) begin
      status_d = ffba_pkg::ST_FULL;
    end else begin
      apply_op = ffba_pkg::OP_SPLIT;
      offset_d = sel_start_i;
      count_d  = count_q + CNT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffba_pkg::FSM_IDLE: begin
        if (in_fire) begin
          state_d = ffba_pkg::FSM_SEARCH;
        end
      end
      ffba_pkg::FSM_SEARCH: begin
        state_d = ffba_pkg::FSM_APPLY;
      end
      ffba_pkg::FSM_APPLY: begin
        if (apply_go) begin
          state_d = ffba_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = ffba_pkg::FSM_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.op       = ffba_pkg::OP_NONE;
    cmd_o.req_free = free_q;
    cmd_o.need     = need_q;
    cmd_o.where    = where_q;
    cmd_o.arena    = cfg_wdata_i;
    case (state_q)
      ffba_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (cfg_we_i) begin
          cmd_o.op = ffba_pkg::OP_CLEAR;
        end
      end
      ffba_pkg::FSM_SEARCH: begin
        cmd_o.op = ffba_pkg::OP_SEARCH;
      end
      ffba_pkg::FSM_APPLY: begin
        if (apply_go) begin
          cmd_o.op = apply_op;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_offset_o = offset_q;
  assign out_count_o  = ffba_pkg::COUNT_OUT_W'(out_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::FSM_IDLE;
      count_q     <= CNT_W'(1);
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= CNT_W'(1);
      end else if (apply_go) begin
        count_q <= count_d;
      end
      if (state_q == ffba_pkg::FSM_SEARCH) begin
        found_q <= found_i;
      end
      if (apply_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      free_q  <= in_free_i;
      need_q  <= need_in;
      where_q <= in_where_i;
    end
    if (apply_go) begin
      status_q    <= status_d;
      offset_q    <= offset_d;
      out_count_q <= count_d;
    end
  end

  `FFBA_ASSERT(a_count_range, (count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_SEGMENTS)))
  `FFBA_ASSERT_NEXT(a_apply_shows, apply_go, out_valid_q)
  `FFBA_ASSERT_NEXT(a_search_then_apply, state_q == ffba_pkg::FSM_SEARCH,
                    state_q == ffba_pkg::FSM_APPLY)
  `FFBA_ASSERT(a_bad_status_zero, !out_valid_q || (status_q == ffba_pkg::ST_OK)
               || (offset_q == '0))

endmodule

`default_nettype wire

>>> rtl/core/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an address-ordered chain of segment cells.
// ----------------------------------------------------------------------------
// One request at a time: accepted while idle, then searched, then applied.
// The cell chain is searched in the search state and updated (mark or
//   split-with-shift) in the apply state, which waits while a result is held.
// Reset: asynchronous; the table holds one 65536-byte hole, count is 1.
// An idle config write reloads the table to one hole of size (wdata & ~3).
`default_nettype none

`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator #(
  parameter int unsigned MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [23:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // alloc_bytes[23:0], free_offset[47:24]
  input  wire         s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata    // status[1:0], block_offset[25:2],
                                      // segment_count[32:26], zero[39:33]
);

  ffba_pkg::cell_cmd_t         cmd;
  ffba_pkg::cell_link_t        links [MAX_SEGMENTS];
  ffba_pkg::cell_link_t        head_prev;
  logic [ffba_pkg::ADDR_W-1:0] cell_start [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0]     cell_exact;
  logic [MAX_SEGMENTS-1:0]     sel_vec;
  logic [ffba_pkg::ADDR_W-1:0] sel_start;
  logic                        sel_exact;
  logic [1:0]                  out_status;
  logic [ffba_pkg::ADDR_W-1:0] out_offset;
  logic [6:0]                  out_count;

  assign head_prev = '0;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    ffba_cell #(
      .HEAD (i == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .prev_i      ((i == 0) ? head_prev : links[(i == 0) ? 0 : i-1]),
      .link_o      (links[i]),
      .sel_start_o (cell_start[i]),
      .sel_exact_o (cell_exact[i])
    );
    assign sel_vec[i] = links[i].sel;
  end

  always_comb begin
    sel_start = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      sel_start = sel_start | cell_start[i];
    end
  end

  assign sel_exact = |cell_exact;

  ffba_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_free_i    (s_axis_tuser),
    .in_bytes_i   (s_axis_tdata[23:0]),
    .in_where_i   (s_axis_tdata[47:24]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_offset_o (out_offset),
    .out_count_o  (out_count),
    .found_i      (links[MAX_SEGMENTS-1].hit),
    .sel_exact_i  (sel_exact),
    .sel_start_i  (sel_start),
    .cmd_o        (cmd)
  );

  assign m_axis_tdata = {7'b0, out_count, out_offset, out_status};

  `FFBA_ASSERT(a_sel_onehot0, $onehot0(sel_vec))
  `FFBA_ASSERT(a_head_live, links[0].live)
  `FFBA_ASSERT_NEXT(a_split_grows, cmd.op == ffba_pkg::OP_SPLIT,
                    $countones(sel_vec) <= 1)

endmodule

`default_nettype wire

>>> bench/first_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit block allocator. A behavioral
// segment table predicts status, offset and segment count for every accepted
// request. Directed edge cases come first, then a table-full sequence, then
// randomized allocate/free traffic over several arena sizes, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEG_SLOTS    = ffba_pkg::MAX_SEGMENTS_DEF;
  localparam logic        REQ_ALLOC    = 1'b0;
  localparam logic        REQ_FREE     = 1'b1;
  localparam int unsigned APPLY_CYCLES = 6;

  typedef struct packed {
    ffba_pkg::status_e status;
    logic [23:0]       offset;
    logic [6:0]        count;
  } alloc_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [23:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // alloc_bytes[23:0], free_offset[47:24]
  logic        s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // status[1:0], block_offset[25:2],
                               // segment_count[32:26], zero[39:33]

  first_fit_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // segment table shadow
  logic [23:0]   arena_m;
  logic [23:0]   seg_start_m [SEG_SLOTS];
  logic [23:0]   seg_len_m   [SEG_SLOTS];
  logic          seg_blk_m   [SEG_SLOTS];
  int unsigned   live_m;
  alloc_result_t result_q [$];
  int unsigned   err_count;
  bit            idle_on;

  function automatic void reload_table(input logic [23:0] bytes);
    arena_m = bytes & 24'hFFFFFC;
    for (int i = 0; i < SEG_SLOTS; i++) begin
      seg_start_m[i] = '0;
      seg_len_m[i]   = '0;
      seg_blk_m[i]   = 1'b0;
    end
    seg_len_m[0] = arena_m;
    live_m       = 1;
  endfunction

  function automatic alloc_result_t predict_alloc(input logic [23:0] bytes);
    alloc_result_t res;
    logic [24:0]   need;
    int            hit;
    res.status = ffba_pkg::ST_OK;
    res.offset = '0;
    need = ({1'b0, bytes} + 25'd3) & ~25'd3;
    hit  = -1;
    for (int i = 0; i < int'(live_m); i++) begin
      if (hit < 0 && !seg_blk_m[i] && {1'b0, seg_len_m[i]} >= need) hit = i;
    end
    if (need == '0 || hit < 0) begin
      res.status = ffba_pkg::ST_NOFIT;
    end else if ({1'b0, seg_len_m[hit]} == need) begin
      seg_blk_m[hit] = 1'b1;
      res.offset     = seg_start_m[hit];
    end else if (live_m >= SEG_SLOTS) begin
      res.status = ffba_pkg::ST_FULL;
    end else begin
      for (int j = int'(live_m); j > hit + 1; j--) begin
        seg_start_m[j] = seg_start_m[j-1];
        seg_len_m[j]   = seg_len_m[j-1];
        seg_blk_m[j]   = seg_blk_m[j-1];
      end
      seg_start_m[hit+1] = seg_start_m[hit] + need[23:0];
      seg_len_m[hit+1]   = seg_len_m[hit] - need[23:0];
      seg_blk_m[hit+1]   = 1'b0;
      seg_len_m[hit]     = need[23:0];
      seg_blk_m[hit]     = 1'b1;
      live_m++;
      res.offset = seg_start_m[hit];
    end
    res.count = 7'(live_m);
    return res;
  endfunction

  function automatic alloc_result_t predict_free(input logic [23:0] where);
    alloc_result_t res;
    res.status = ffba_pkg::ST_NOTFOUND;
    res.offset = '0;
    for (int i = 0; i < int'(live_m); i++) begin
      if (res.status == ffba_pkg::ST_NOTFOUND && seg_start_m[i] == where) begin
        seg_blk_m[i] = 1'b0;
        res.status   = ffba_pkg::ST_OK;
        res.offset   = where;
      end
    end
    res.count = 7'(live_m);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [39:0] got,
                                 input logic [39:0] exp);
    err_count++;
    $display("%0t mismatch %s: got %0h expected %0h", $time, field, got, exp);
  endtask

  task automatic check_beat(input logic [39:0] beat);
    alloc_result_t want;
    if (result_q.size() == 0) begin
      report_mismatch("unexpected beat", beat, '0);
      return;
    end
    want = result_q.pop_front();
    if (beat[1:0] !== want.status)
      report_mismatch("status", 40'(beat[1:0]), 40'(want.status));
    if (beat[25:2] !== want.offset)
      report_mismatch("offset", 40'(beat[25:2]), 40'(want.offset));
    if (beat[32:26] !== want.count)
      report_mismatch("count", 40'(beat[32:26]), 40'(want.count));
    if (beat[39:33] !== '0) report_mismatch("pad bits", 40'(beat[39:33]), '0);
  endtask

  // result side: random stall after each beat while idle_on is set
  initial begin : result_side
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        check_beat(m_axis_tdata);
        stall_left = idle_on ? $urandom_range(0, 6) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic send_request(input logic req, input logic [23:0] bytes,
                              input logic [23:0] where);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {where, bytes};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (req == REQ_ALLOC) result_q.push_back(predict_alloc(bytes));
    else result_q.push_back(predict_free(where));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (APPLY_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_arena(input logic [23:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reload_table(value);
  endtask

  task automatic send_random_item(input int unsigned max_bytes);
    int unsigned roll;
    int unsigned idx;
    logic [23:0] junk;
    logic [23:0] fit_bytes;
    roll      = $urandom_range(0, 99);
    idx       = $urandom_range(0, live_m - 1);
    junk      = 24'($urandom());
    fit_bytes = seg_len_m[idx] - 24'($urandom_range(0, 3));
    if (roll < 30) send_request(REQ_ALLOC, 24'($urandom_range(1, 64)), junk);
    else if (roll < 45) send_request(REQ_ALLOC, 24'($urandom_range(1, max_bytes)), junk);
    else if (roll < 55) send_request(REQ_ALLOC, fit_bytes, junk);
    else if (roll < 85) send_request(REQ_FREE, junk, seg_start_m[idx]);
    else if (roll < 93) send_request(REQ_FREE, 24'($urandom()), junk);
    else send_request(REQ_ALLOC, junk, 24'($urandom()));
  endtask

  // reset arena of 65536
  task automatic test_request_edges();
    send_request(REQ_FREE,  24'($urandom()), 24'h000000); // free of a hole
    send_request(REQ_ALLOC, 24'h000000, 24'($urandom())); // zero size
    send_request(REQ_ALLOC, 24'hFFFFFF, 24'($urandom())); // rounds past 24 bits
    send_request(REQ_ALLOC, 24'hFFFFFD, 24'($urandom()));
    send_request(REQ_ALLOC, 24'h000001, 24'($urandom()));
    send_request(REQ_ALLOC, 24'h000006, 24'($urandom()));
    send_request(REQ_FREE,  24'($urandom()), 24'h123457); // unknown offset
    send_request(REQ_FREE,  24'($urandom()), 24'hFFFFFF);
    send_request(REQ_ALLOC, 24'd65536, 24'($urandom()));  // no fitting hole
    send_request(REQ_ALLOC, 24'd65524, 24'($urandom()));  // exact fit
    send_request(REQ_ALLOC, 24'd4, 24'($urandom()));
    send_request(REQ_FREE,  24'($urandom()), 24'd4);
    send_request(REQ_ALLOC, 24'd9, 24'($urandom()));
    send_request(REQ_ALLOC, 24'd8, 24'($urandom()));
    send_request(REQ_FREE,  24'($urandom()), 24'd0);
    send_request(REQ_FREE,  24'($urandom()), 24'd12);
    send_request(REQ_ALLOC, 24'd65521, 24'($urandom()));
  endtask

  task automatic test_arena_register();
    write_arena(24'd7);                                   // unaligned size
    send_request(REQ_ALLOC, 24'd4, 24'($urandom()));
    send_request(REQ_ALLOC, 24'd1, 24'($urandom()));
    write_arena(24'd0);
    send_request(REQ_ALLOC, 24'd1, 24'($urandom()));
    send_request(REQ_FREE,  24'($urandom()), 24'd0);
    write_arena(24'hFFFFFF);
    send_request(REQ_ALLOC, 24'hFFFFFC, 24'($urandom()));
    send_request(REQ_FREE,  24'($urandom()), 24'd0);
    send_request(REQ_ALLOC, 24'h800001, 24'($urandom()));
    send_request(REQ_ALLOC, 24'h7FFFF8, 24'($urandom()));
    send_request(REQ_FREE,  24'($urandom()), 24'h800004);
  endtask

  task automatic test_table_full();
    int unsigned idx;
    idle_on = 1'b1;
    write_arena(24'd4096);
    repeat (SEG_SLOTS - 1) send_request(REQ_ALLOC, 24'($urandom_range(1, 16)), 24'($urandom()));
    send_request(REQ_ALLOC, 24'd4, 24'($urandom()));      // split refused
    send_request(REQ_ALLOC, 24'd5000, 24'($urandom()));
    send_request(REQ_ALLOC, seg_len_m[live_m-1], 24'($urandom())); // exact fit when full
    repeat (6) begin
      idx = $urandom_range(0, live_m - 1);
      send_request(REQ_FREE, 24'($urandom()), seg_start_m[idx]);
      send_request(REQ_ALLOC, seg_len_m[idx], 24'($urandom()));
    end
  endtask

  task automatic test_random_traffic(input logic [23:0] arena, input int unsigned count,
                                     input int unsigned max_bytes, input bit with_idle,
                                     input bit drain_midway);
    write_arena(arena);
    idle_on = with_idle;
    for (int unsigned n = 0; n < count; n++) begin
      if (drain_midway && n == count / 2) wait_drained();
      send_random_item(max_bytes);
    end
  endtask

  initial begin : timeout_guard
    #5_000_000;
    $display("first_fit_block_allocator verification failed");
    $finish;
  end

  initial begin : run_all
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_ALLOC;
    err_count     = 0;
    idle_on       = 1'b1;
    reload_table(ffba_pkg::RESET_ARENA);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_request_edges();
    test_arena_register();
    test_table_full();
    test_random_traffic(24'hFFFFFC, 400, 1 << 20, 1'b1, 1'b0);
    test_random_traffic(24'd1023,   300, 64,      1'b0, 1'b0);
    test_random_traffic(24'd65536,  400, 4096,    1'b1, 1'b1);
    test_random_traffic(24'hFFFFFF, 300, 1 << 23, 1'b1, 1'b0);
    test_random_traffic(24'd0,      30,  64,      1'b1, 1'b0);
    test_random_traffic(24'd200,    300, 32,      1'b1, 1'b0);

    wait_drained();
    if (err_count == 0 && result_q.size() == 0) begin
      $display("first_fit_block_allocator verification clean");
    end else begin
      $display("first_fit_block_allocator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator.sv
bench/first_fit_block_allocator_tb.sv
